>>> rtl/core/jsu_pkg.sv
// Shared constants, codes and request types for the JSON string unescape unit.
// No dependencies; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package jsu_pkg;

	localparam int OUT_COUNT_BITS = 16;
	localparam int CNT_W = OUT_COUNT_BITS;
	localparam int LIM_W = ((CNT_W > 16) ? CNT_W : 16) + 1;
	localparam logic [LIM_W-1:0] CNT_LIMIT = LIM_W'(1) << CNT_W;

	localparam int MAX_RES = 7;
	localparam int NB_W = $clog2(MAX_RES + 1);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [15:0] CAP_RESET = 16'd256;

	localparam logic [15:0] SURR_HI_MIN = 16'hD800;
	localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
	localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
	localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
	localparam logic [20:0] CP_SUPP = 21'h10000;
	localparam logic [20:0] CP_REPL = 21'h0FFFD;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_U = 8'h75;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_DONE = 2'd1,
		KIND_FAIL = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_ESCAPE = 3'd1,
		ERR_HEX = 3'd2,
		ERR_FULL = 3'd3,
		ERR_END = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		TERM_NONE,
		TERM_DONE,
		TERM_FAIL
	} term_t;

	typedef enum logic [2:0] {
		PH_TEXT,
		PH_ESC,
		PH_HEX1,
		PH_HIGH,
		PH_BSL,
		PH_HEX2
	} phase_t;

	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [NB_W-1:0] nbytes;
		term_t term;
		err_t err;
		logic [CNT_W-1:0] base;
	} cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/jsu_if.sv
// Channel interfaces of the JSON string unescape unit: raw text in, decoded results out.
// Depends on jsu_pkg for the result codes.
`default_nettype none

interface jsu_text_if;
	logic valid;
	logic ready;
	logic begin_req;
	logic [7:0] data_byte;

	modport source (output valid, output begin_req, output data_byte, input ready);
	modport sink (input valid, input begin_req, input data_byte, output ready);
endinterface

interface jsu_result_if;
	logic valid;
	logic ready;
	jsu_pkg::kind_t kind;
	logic [7:0] out_byte;
	jsu_pkg::err_t error_code;
	logic [15:0] out_length;
	logic last;

	modport source (output valid, output kind, output out_byte, output error_code,
		output out_length, output last, input ready);
	modport sink (input valid, input kind, input out_byte, input error_code,
		input out_length, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/json_string_unescape_utf8_unit.sv
// Top level of the JSON string unescape unit: front end, command queue, back end.
// Depends on jsu_pkg, jsu_if, jsu_front, jsu_queue and jsu_back.
//
//   port      role     handshake         payload
//   text      sink     valid/ready       begin_req, data_byte
//   decoded   source   valid/ready       kind, out_byte, error_code, out_length, last
//   cfg       write    cfg_wr_en         cfg_wr_data (output capacity)
//
// A request is taken every cycle while the command queue (four entries) has room.
// Each request yields up to seven results, presented one per cycle by the back end while decoded.ready is high,
// so the rate of results per cycle is set by the back end's output register.
// Reset clears the decoder state and the queue; the capacity returns to 256.
// A stall on decoded fills the queue, after which text.ready drops.
`default_nettype none

module json_string_unescape_utf8_unit (
	input logic clk,
	input logic arst_n,
	jsu_text_if.sink text,
	jsu_result_if.source decoded,
	input logic cfg_wr_en,
	input logic [15:0] cfg_wr_data
);

	logic push, full, pop, q_valid;
	jsu_pkg::cmd_t wr_cmd, head;

	jsu_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.text(text),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.q_full(full),
		.push(push),
		.cmd(wr_cmd)
	);

	jsu_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_cmd(wr_cmd),
		.full(full),
		.pop(pop),
		.q_valid(q_valid),
		.head(head)
	);

	jsu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.head(head),
		.pop(pop),
		.result(decoded)
	);

endmodule

`default_nettype wire

>>> rtl/core/jsu_front.sv
// Front end: accepts raw text bytes, tracks the escape state and the output count,
// and turns each request that yields results into one command of up to seven results. Uses jsu_pkg, jsu_if.
`default_nettype none

module jsu_front (
	input logic clk,
	input logic arst_n,
	jsu_text_if.sink text,
	input logic cfg_wr_en,
	input logic [15:0] cfg_wr_data,
	input logic q_full,
	output logic push,
	output jsu_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_PLAIN,
		TAIL_ESC
	} tail_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0] len;
	} utf8_t;

	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp < 21'h80) begin
			r.b[0] = cp[7:0];
			r.len = 3'd1;
		end else if (cp < 21'h800) begin
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
			r.len = 3'd2;
		end else if (cp < 21'h10000) begin
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
			r.len = 3'd3;
		end else begin
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
			r.len = 3'd4;
		end
		return r;
	endfunction

	function automatic logic [4:0] hex_dec(input logic [7:0] c);
		logic [7:0] d;
		d = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
			return {1'b1, d[3:0]};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
			return {1'b1, d[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

	function automatic logic [8:0] esc_map(input logic [7:0] c);
		logic [8:0] r;
		unique case (c)
			8'h6E: r = {1'b1, 8'h0A};
			8'h74: r = {1'b1, 8'h09};
			8'h72: r = {1'b1, 8'h0D};
			8'h62: r = {1'b1, 8'h08};
			8'h66: r = {1'b1, 8'h0C};
			8'h22: r = {1'b1, 8'h22};
			8'h5C: r = {1'b1, 8'h5C};
			8'h2F: r = {1'b1, 8'h2F};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	logic [15:0] cap_q;
	logic active_q, act_d;
	jsu_pkg::phase_t phase_q, phase_d;
	logic [1:0] hcnt_q, hcnt_d;
	logic [15:0] hi_q, hi_d, lo_q, lo_d, hi_nx, lo_nx;
	logic [7:0] pend_q [4];
	logic [jsu_pkg::CNT_W-1:0] wcount_q, wc_d;

	logic acc, live, pend_we;
	logic [7:0] b;
	logic hok;
	logic [3:0] hv;
	logic esc_ok;
	logic [7:0] esc_byte;
	logic use_head;
	logic [20:0] head_cp;
	logic [2:0] npend, hlen;
	tail_t tail;
	logic tail_emit;
	logic [7:0] tail_byte;
	utf8_t enc;
	logic [jsu_pkg::MAX_RES-1:0][7:0] seq;
	logic [jsu_pkg::NB_W-1:0] pos, nraw, nb;
	jsu_pkg::term_t term_raw, term;
	jsu_pkg::err_t err_raw, err;
	logic [jsu_pkg::LIM_W-1:0] cap_ext, lim, w_ext, room;
	logic room_ok, fit;

	assign text.ready = !q_full;

	always_comb begin
		acc = text.valid && text.ready;
		b = text.data_byte;
		{hok, hv} = hex_dec(b);
		{esc_ok, esc_byte} = esc_map(b);
		hi_nx = {hi_q[11:0], hv};
		lo_nx = {lo_q[11:0], hv};

		act_d = active_q;
		phase_d = phase_q;
		hcnt_d = hcnt_q;
		hi_d = hi_q;
		lo_d = lo_q;
		pend_we = 1'b0;
		use_head = 1'b0;
		head_cp = jsu_pkg::CP_REPL;
		npend = 3'd0;
		tail = TAIL_NONE;
		term_raw = jsu_pkg::TERM_NONE;
		err_raw = jsu_pkg::ERR_NONE;

		unique case (phase_q)
			jsu_pkg::PH_ESC: begin
				phase_d = jsu_pkg::PH_TEXT;
				tail = TAIL_ESC;
			end
			jsu_pkg::PH_HEX1: begin
				if (!hok) begin
					term_raw = jsu_pkg::TERM_FAIL;
					err_raw = (b == jsu_pkg::CH_NUL) ? jsu_pkg::ERR_END : jsu_pkg::ERR_HEX;
				end else begin
					hi_d = hi_nx;
					hcnt_d = hcnt_q + 2'd1;
					if (hcnt_q == 2'd3) begin
						if (hi_nx >= jsu_pkg::SURR_HI_MIN && hi_nx <= jsu_pkg::SURR_HI_MAX) begin
							phase_d = jsu_pkg::PH_HIGH;
						end else begin
							phase_d = jsu_pkg::PH_TEXT;
							use_head = 1'b1;
							if (hi_nx < jsu_pkg::SURR_HI_MIN || hi_nx > jsu_pkg::SURR_LO_MAX) begin
								head_cp = {5'd0, hi_nx};
							end
						end
					end
				end
			end
			jsu_pkg::PH_HIGH: begin
				if (b == jsu_pkg::CH_BSL) begin
					phase_d = jsu_pkg::PH_BSL;
				end else begin
					phase_d = jsu_pkg::PH_TEXT;
					use_head = 1'b1;
					tail = TAIL_PLAIN;
				end
			end
			jsu_pkg::PH_BSL: begin
				if (b == jsu_pkg::CH_U) begin
					phase_d = jsu_pkg::PH_HEX2;
					hcnt_d = 2'd0;
					lo_d = 16'd0;
				end else begin
					phase_d = jsu_pkg::PH_TEXT;
					use_head = 1'b1;
					tail = TAIL_ESC;
				end
			end
			jsu_pkg::PH_HEX2: begin
				if (!hok) begin
					phase_d = jsu_pkg::PH_TEXT;
					use_head = 1'b1;
					npend = {1'b0, hcnt_q};
					tail = TAIL_PLAIN;
				end else begin
					pend_we = 1'b1;
					lo_d = lo_nx;
					hcnt_d = hcnt_q + 2'd1;
					if (hcnt_q == 2'd3) begin
						phase_d = jsu_pkg::PH_TEXT;
						use_head = 1'b1;
						if (lo_nx >= jsu_pkg::SURR_LO_MIN && lo_nx <= jsu_pkg::SURR_LO_MAX) begin
							head_cp = jsu_pkg::CP_SUPP + {1'b0, hi_q[9:0], lo_nx[9:0]};
						end else begin
							npend = 3'd4;
						end
					end
				end
			end
			default: begin
				tail = TAIL_PLAIN;
			end
		endcase

		tail_emit = 1'b0;
		tail_byte = b;
		unique case (tail)
			TAIL_PLAIN: begin
				priority if (b == jsu_pkg::CH_NUL) begin
					term_raw = jsu_pkg::TERM_FAIL;
					err_raw = jsu_pkg::ERR_END;
				end else if (b == jsu_pkg::CH_QUOTE) begin
					term_raw = jsu_pkg::TERM_DONE;
				end else if (b == jsu_pkg::CH_BSL) begin
					phase_d = jsu_pkg::PH_ESC;
				end else begin
					tail_emit = 1'b1;
				end
			end
			TAIL_ESC: begin
				priority if (b == jsu_pkg::CH_NUL) begin
					term_raw = jsu_pkg::TERM_FAIL;
					err_raw = jsu_pkg::ERR_END;
				end else if (esc_ok) begin
					tail_emit = 1'b1;
					tail_byte = esc_byte;
				end else if (b == jsu_pkg::CH_U) begin
					phase_d = jsu_pkg::PH_HEX1;
					hcnt_d = 2'd0;
					hi_d = 16'd0;
				end else begin
					term_raw = jsu_pkg::TERM_FAIL;
					err_raw = jsu_pkg::ERR_ESCAPE;
				end
			end
			default: begin
			end
		endcase

		enc = utf8_enc(head_cp);
		hlen = use_head ? enc.len : 3'd0;
		seq = '0;
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < hlen) begin
				seq[i] = enc.b[i];
			end
		end
		// Pending hex characters only ever follow a replacement character.
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < npend) begin
				seq[i + 3] = (i == 3) ? b : pend_q[i];
			end
		end
		pos = jsu_pkg::NB_W'(hlen + npend);
		if (tail_emit) begin
			seq[pos] = tail_byte;
		end
		nraw = pos + jsu_pkg::NB_W'(tail_emit);

		cap_ext = jsu_pkg::LIM_W'(cap_q);
		lim = (cap_ext < jsu_pkg::CNT_LIMIT) ? cap_ext : jsu_pkg::CNT_LIMIT;
		w_ext = jsu_pkg::LIM_W'(wcount_q);
		room_ok = lim > w_ext;
		room = lim - w_ext - jsu_pkg::LIM_W'(1);
		fit = (nraw == '0) || (room_ok && (room >= jsu_pkg::LIM_W'(nraw)));
		if (fit) begin
			nb = nraw;
			term = term_raw;
			err = err_raw;
		end else begin
			nb = room_ok ? room[jsu_pkg::NB_W-1:0] : '0;
			term = jsu_pkg::TERM_FAIL;
			err = jsu_pkg::ERR_FULL;
		end

		if (term != jsu_pkg::TERM_NONE) begin
			act_d = 1'b0;
			phase_d = jsu_pkg::PH_TEXT;
		end
		wc_d = wcount_q + jsu_pkg::CNT_W'(nb);

		live = active_q && !text.begin_req;
		if (text.begin_req) begin
			act_d = 1'b1;
			phase_d = jsu_pkg::PH_TEXT;
			hcnt_d = 2'd0;
			hi_d = 16'd0;
			lo_d = 16'd0;
			wc_d = '0;
		end else if (!active_q) begin
			act_d = active_q;
			phase_d = phase_q;
			hcnt_d = hcnt_q;
			hi_d = hi_q;
			lo_d = lo_q;
			wc_d = wcount_q;
		end

		push = acc && live && (nb != '0 || term != jsu_pkg::TERM_NONE);
		cmd.bytes = seq;
		cmd.nbytes = nb;
		cmd.term = term;
		cmd.err = err;
		cmd.base = wcount_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= jsu_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q <= jsu_pkg::PH_TEXT;
			hcnt_q <= 2'd0;
			hi_q <= 16'd0;
			lo_q <= 16'd0;
			wcount_q <= '0;
		end else if (acc) begin
			active_q <= act_d;
			phase_q <= phase_d;
			hcnt_q <= hcnt_d;
			hi_q <= hi_d;
			lo_q <= lo_d;
			wcount_q <= wc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && live && pend_we) begin
			pend_q[hcnt_q] <= b;
		end
	end

	a_close_after_term: assert property (@(posedge clk) disable iff (!arst_n)
		push && cmd.term != jsu_pkg::TERM_NONE |=> !active_q)
		else $error("literal still open after a finish or failure request");

endmodule

`default_nettype wire

>>> rtl/core/jsu_queue.sv
// Short command queue between the front and back ends of the unescape unit.
// Register based, QDEPTH entries of jsu_pkg::cmd_t.
`default_nettype none

module jsu_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input jsu_pkg::cmd_t wr_cmd,
	output logic full,
	input logic pop,
	output logic q_valid,
	output jsu_pkg::cmd_t head
);

	jsu_pkg::cmd_t mem_q [jsu_pkg::QDEPTH];
	logic [jsu_pkg::QPTR_W-1:0] wp_q, rp_q;
	logic [jsu_pkg::QPTR_W:0] cnt_q;

	assign full = (cnt_q == (jsu_pkg::QPTR_W + 1)'(jsu_pkg::QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign head = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_valid)
		else $error("command queue read while empty");

endmodule

`default_nettype wire

>>> rtl/core/jsu_back.sv
// Back end: walks the command at the head of the queue and presents its results,
// one per cycle while result.ready does not hold them off, through an output register. Uses jsu_pkg and jsu_if.
`default_nettype none

module jsu_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input jsu_pkg::cmd_t head,
	output logic pop,
	jsu_result_if.source result
);

	logic [jsu_pkg::NB_W-1:0] idx_q, idx1, total;
	logic ov_q;
	jsu_pkg::kind_t kind_q, kind_nx;
	logic [7:0] byte_q, byte_nx;
	jsu_pkg::err_t err_q, err_nx;
	logic [15:0] len_q, len_nx;
	logic last_q;
	logic has_term, is_last, in_bytes, load;

	always_comb begin
		has_term = (head.term != jsu_pkg::TERM_NONE);
		total = head.nbytes + jsu_pkg::NB_W'(has_term);
		is_last = (idx_q == total - 1'b1);
		load = q_valid && (!ov_q || result.ready);
		pop = load && is_last;
		in_bytes = (idx_q < head.nbytes);
		idx1 = idx_q + 1'b1;
		if (in_bytes) begin
			kind_nx = jsu_pkg::KIND_BYTE;
			byte_nx = head.bytes[idx_q];
			err_nx = jsu_pkg::ERR_NONE;
			len_nx = 16'(head.base + jsu_pkg::CNT_W'(idx1));
		end else begin
			kind_nx = (head.term == jsu_pkg::TERM_DONE) ? jsu_pkg::KIND_DONE : jsu_pkg::KIND_FAIL;
			byte_nx = 8'd0;
			err_nx = head.err;
			len_nx = 16'(head.base + jsu_pkg::CNT_W'(head.nbytes));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
				idx_q <= is_last ? '0 : idx1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_nx;
			byte_q <= byte_nx;
			err_q <= err_nx;
			len_q <= len_nx;
			last_q <= is_last;
		end
	end

	assign result.valid = ov_q;
	assign result.kind = kind_q;
	assign result.out_byte = byte_q;
	assign result.error_code = err_q;
	assign result.out_length = len_q;
	assign result.last = last_q;

	a_term_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind != jsu_pkg::KIND_BYTE |-> result.last)
		else $error("finish or failure result not marked last");

	a_head_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> (head.nbytes != '0 || head.term != jsu_pkg::TERM_NONE))
		else $error("queued request carries no result");

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking bench for json_string_unescape_utf8_unit: a table of directed requests, then random
// literals under several output capacities; results are checked against the table or a decoder model.
// Depends on jsu_pkg, jsu_if and the unit's RTL.
`default_nettype none

module testbench;
	import jsu_pkg::*;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_ONE
	} row_chk_t;

	typedef struct packed {
		logic beg;
		logic [7:0] data;
		row_chk_t chk;
		kind_t kind;
		logic [7:0] ob;
		err_t err;
		logic [15:0] len;
	} row_t;

	typedef struct {
		kind_t kind;
		logic [7:0] ob;
		err_t err;
		logic [15:0] len;
		logic last;
	} result_t;

	localparam longint COUNT_MAX = (64'd1 << OUT_COUNT_BITS) - 1;

	localparam row_t DIRECTED [0:26] = '{
		'{1'b0, "A", CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b1, CH_QUOTE, CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, "a", CHK_ONE, KIND_BYTE, 8'h61, ERR_NONE, 16'd1},
		'{1'b0, 8'hFF, CHK_ONE, KIND_BYTE, 8'hFF, ERR_NONE, 16'd2},
		'{1'b0, CH_BSL, CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, CH_U, CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, "0", CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, "0", CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, "e", CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, "9", CHK_MODEL, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, CH_BSL, CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, CH_U, CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, "D", CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, "8", CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, "3", CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, "d", CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, "z", CHK_MODEL, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, CH_QUOTE, CHK_ONE, KIND_DONE, 8'h00, ERR_NONE, 16'd8},
		'{1'b1, CH_NUL, CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, CH_BSL, CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, "q", CHK_ONE, KIND_FAIL, 8'h00, ERR_ESCAPE, 16'd0},
		'{1'b1, CH_QUOTE, CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, CH_NUL, CHK_ONE, KIND_FAIL, 8'h00, ERR_END, 16'd0},
		'{1'b1, CH_QUOTE, CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, CH_BSL, CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, CH_U, CHK_NONE, KIND_BYTE, 8'h00, ERR_NONE, 16'd0},
		'{1'b0, "g", CHK_ONE, KIND_FAIL, 8'h00, ERR_HEX, 16'd0}
	};

	localparam logic [15:0] CAP_PLAN [0:6] = '{16'd1, 16'd2, 16'd12, 16'hFFFF, 16'd40, 16'd5,
		16'd256};
	localparam logic [7:0] ESC_LETTERS [0:7] = '{"n", "t", "r", "b", "f", CH_QUOTE, CH_BSL, "/"};

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [15:0] cfg_wr_data;

	jsu_text_if text_bus ();
	jsu_result_if result_bus ();

	json_string_unescape_utf8_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_bus),
		.decoded(result_bus),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	logic [15:0] capacity_m;
	logic open_m;
	phase_t ph_m;
	int unsigned hex_n;
	logic [15:0] hi_m;
	logic [15:0] lo_m;
	logic [7:0] held_hex [0:3];
	int unsigned count_m;
	logic stop_m;

	result_t step_res [$];
	result_t decoded_q [$];
	int taken_reqs = 0;
	int errors = 0;
	logic gaps_on = 1'b1;
	logic long_hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("testbench: errors");
		$finish;
	end

	function automatic int hex_val(input logic [7:0] b);
		if (b >= "0" && b <= "9")
			return b - "0";
		if (b >= "a" && b <= "f")
			return b - "a" + 10;
		if (b >= "A" && b <= "F")
			return b - "A" + 10;
		return -1;
	endfunction

	function automatic void push_res(input kind_t k, input logic [7:0] b, input err_t e);
		if (stop_m || step_res.size() >= MAX_RES)
			return;
		step_res.push_back('{k, b, e, count_m[15:0], 1'b0});
	endfunction

	function automatic void close_literal();
		stop_m = 1'b1;
		open_m = 1'b0;
		ph_m = PH_TEXT;
	endfunction

	function automatic void fail_literal(input err_t e);
		push_res(KIND_FAIL, 8'h00, e);
		close_literal();
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		if (stop_m)
			return;
		if (count_m + 1 >= capacity_m || count_m + 1 > COUNT_MAX) begin
			fail_literal(ERR_FULL);
		end else begin
			count_m++;
			push_res(KIND_BYTE, b, ERR_NONE);
		end
	endfunction

	function automatic void put_cp(input logic [20:0] cp);
		if (cp < 21'h80) begin
			put_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			put_byte({3'b110, cp[10:6]});
			put_byte({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			put_byte({4'b1110, cp[15:12]});
			put_byte({2'b10, cp[11:6]});
			put_byte({2'b10, cp[5:0]});
		end else begin
			put_byte({5'b11110, cp[20:18]});
			put_byte({2'b10, cp[17:12]});
			put_byte({2'b10, cp[11:6]});
			put_byte({2'b10, cp[5:0]});
		end
	endfunction

	function automatic void flush_hex(input int unsigned n);
		for (int unsigned i = 0; i < n && i < 4; i++)
			put_byte(held_hex[i]);
	endfunction

	function automatic void take_plain(input logic [7:0] b);
		if (stop_m)
			return;
		if (b == CH_NUL) begin
			fail_literal(ERR_END);
		end else if (b == CH_QUOTE) begin
			push_res(KIND_DONE, 8'h00, ERR_NONE);
			close_literal();
		end else if (b == CH_BSL) begin
			ph_m = PH_ESC;
		end else begin
			put_byte(b);
		end
	endfunction

	function automatic void take_escape(input logic [7:0] b);
		logic [7:0] v;
		if (stop_m)
			return;
		v = 8'h00;
		case (b)
			CH_NUL: begin
				fail_literal(ERR_END);
				return;
			end
			"n": v = 8'h0A;
			"t": v = 8'h09;
			"r": v = 8'h0D;
			"b": v = 8'h08;
			"f": v = 8'h0C;
			CH_QUOTE, CH_BSL, "/": v = b;
			CH_U: begin
				ph_m = PH_HEX1;
				hex_n = 0;
				hi_m = 16'h0000;
				return;
			end
			default: begin
				fail_literal(ERR_ESCAPE);
				return;
			end
		endcase
		ph_m = PH_TEXT;
		put_byte(v);
	endfunction

	// Works out every result that one accepted request causes, in order, into step_res.
	function automatic void decode_req(input logic beg, input logic [7:0] b);
		int v;
		step_res.delete();
		stop_m = 1'b0;
		if (beg) begin
			open_m = 1'b1;
			ph_m = PH_TEXT;
			hex_n = 0;
			hi_m = 16'h0000;
			lo_m = 16'h0000;
			count_m = 0;
			return;
		end
		if (!open_m)
			return;
		v = hex_val(b);
		case (ph_m)
			PH_ESC: take_escape(b);
			PH_HEX1: begin
				if (v < 0) begin
					fail_literal(b == CH_NUL ? ERR_END : ERR_HEX);
				end else begin
					hi_m = {hi_m[11:0], v[3:0]};
					hex_n++;
					if (hex_n >= 4) begin
						if (hi_m >= SURR_HI_MIN && hi_m <= SURR_HI_MAX) begin
							ph_m = PH_HIGH;
						end else begin
							ph_m = PH_TEXT;
							put_cp((hi_m >= SURR_HI_MIN && hi_m <= SURR_LO_MAX) ?
								CP_REPL : {5'b0, hi_m});
						end
					end
				end
			end
			PH_HIGH: begin
				if (b == CH_BSL) begin
					ph_m = PH_BSL;
				end else begin
					ph_m = PH_TEXT;
					put_cp(CP_REPL);
					take_plain(b);
				end
			end
			PH_BSL: begin
				if (b == CH_U) begin
					ph_m = PH_HEX2;
					hex_n = 0;
					lo_m = 16'h0000;
				end else begin
					ph_m = PH_TEXT;
					put_cp(CP_REPL);
					take_escape(b);
				end
			end
			PH_HEX2: begin
				if (v < 0) begin
					ph_m = PH_TEXT;
					put_cp(CP_REPL);
					flush_hex(hex_n);
					take_plain(b);
				end else begin
					held_hex[hex_n % 4] = b;
					lo_m = {lo_m[11:0], v[3:0]};
					hex_n++;
					if (hex_n >= 4) begin
						ph_m = PH_TEXT;
						if (lo_m >= SURR_LO_MIN && lo_m <= SURR_LO_MAX) begin
							put_cp(CP_SUPP + {hi_m[9:0], lo_m[9:0]});
						end else begin
							put_cp(CP_REPL);
							flush_hex(4);
						end
					end
				end
			end
			default: take_plain(b);
		endcase
		if (step_res.size() > 0)
			step_res[step_res.size() - 1].last = 1'b1;
	endfunction

	task automatic send_req(input row_t r);
		if (gaps_on && $urandom_range(99) < 35) begin
			text_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		text_bus.valid <= 1'b1;
		text_bus.begin_req <= r.beg;
		text_bus.data_byte <= r.data;
		@(posedge clk);
		while (!text_bus.ready)
			@(posedge clk);
		decode_req(r.beg, r.data);
		case (r.chk)
			CHK_MODEL: foreach (step_res[i]) decoded_q.push_back(step_res[i]);
			CHK_ONE: decoded_q.push_back('{r.kind, r.ob, r.err, r.len, 1'b1});
			default: ;
		endcase
		taken_reqs++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic beg, input logic [7:0] d);
		row_t r;
		r = '{beg, d, CHK_MODEL, KIND_BYTE, 8'h00, ERR_NONE, 16'h0000};
		send_req(r);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return 8'h30 + n;
		return ($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] d;
		do
			d = 8'($urandom_range(255));
		while (hex_val(d) >= 0);
		return d;
	endfunction

	task automatic send_u(input logic [15:0] w);
		send_byte(1'b0, CH_BSL);
		send_byte(1'b0, CH_U);
		for (int i = 3; i >= 0; i--)
			send_byte(1'b0, hex_char(w[i * 4 +: 4]));
	endtask

	task automatic send_short_u();
		send_byte(1'b0, CH_BSL);
		send_byte(1'b0, CH_U);
		repeat ($urandom_range(3))
			send_byte(1'b0, hex_char(4'($urandom_range(15))));
		send_byte(1'b0, non_hex_byte());
	endtask

	task automatic send_token();
		int pick;
		logic [15:0] w;
		logic [7:0] d;
		pick = $urandom_range(99);
		if (pick < 40) begin
			do
				d = 8'($urandom_range(1, 255));
			while (d == CH_QUOTE || d == CH_BSL);
			send_byte(1'b0, d);
		end else if (pick < 55) begin
			send_byte(1'b0, CH_BSL);
			send_byte(1'b0, ESC_LETTERS[$urandom_range(7)]);
		end else if (pick < 70) begin
			send_u(16'($urandom_range(16'hFFFF)));
		end else if (pick < 82) begin
			send_u(SURR_HI_MIN + 16'($urandom_range(10'h3FF)));
			send_u(SURR_LO_MIN + 16'($urandom_range(10'h3FF)));
		end else if (pick < 92) begin
			send_u(SURR_HI_MIN + 16'($urandom_range(10'h3FF)));
			case ($urandom_range(3))
				0: begin
					do
						d = 8'($urandom_range(255));
					while (d == CH_BSL);
					send_byte(1'b0, d);
				end
				1: begin
					d = $urandom_range(1) ? ESC_LETTERS[$urandom_range(7)] :
						8'($urandom_range(255));
					send_byte(1'b0, CH_BSL);
					send_byte(1'b0, d == CH_U ? 8'h78 : d);
				end
				2: send_short_u();
				default: begin
					w = 16'($urandom_range(16'hFFFF));
					if (w >= SURR_LO_MIN && w <= SURR_LO_MAX)
						w = w ^ 16'h4000;
					send_u(w);
				end
			endcase
		end else begin
			case ($urandom_range(2))
				0: begin
					send_byte(1'b0, CH_BSL);
					send_byte(1'b0, 8'($urandom_range(255)));
				end
				1: send_short_u();
				default: send_byte(1'b0, CH_NUL);
			endcase
		end
	endtask

	task automatic send_literal();
		int n_tok;
		n_tok = $urandom_range(1, 8);
		send_byte(1'b1, $urandom_range(1) ? CH_QUOTE : 8'($urandom_range(255)));
		repeat (n_tok)
			send_token();
		if ($urandom_range(9) != 0)
			send_byte(1'b0, CH_QUOTE);
		if ($urandom_range(7) == 0)
			send_byte(1'b0, 8'($urandom_range(255)));
	endtask

	// Waits until the unit has drained before the capacity register is rewritten.
	task automatic set_capacity(input logic [15:0] v);
		text_bus.valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		capacity_m = v;
	endtask

	initial begin
		int target;
		int guard;
		text_bus.valid = 1'b0;
		text_bus.begin_req = 1'b0;
		text_bus.data_byte = 8'h00;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 16'h0000;
		arst_n = 1'b0;
		capacity_m = CAP_RESET;
		open_m = 1'b0;
		ph_m = PH_TEXT;
		hex_n = 0;
		hi_m = 16'h0000;
		lo_m = 16'h0000;
		count_m = 0;
		stop_m = 1'b0;
		foreach (held_hex[i]) held_hex[i] = 8'h00;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) send_req(DIRECTED[i]);

		foreach (CAP_PLAN[p]) begin
			set_capacity(CAP_PLAN[p]);
			gaps_on = (p != 3);
			target = taken_reqs + ((p == 0) ? 25 : 60);
			while (taken_reqs < target)
				send_literal();
		end

		text_bus.valid <= 1'b0;
		guard = 0;
		while (decoded_q.size() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (20) @(negedge clk);
		if (decoded_q.size() != 0) begin
			$error("%0d expected results never arrived", decoded_q.size());
			errors++;
		end
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// The long hold-off lets the command queue fill so that the text side stalls.
	initial begin
		result_bus.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && taken_reqs >= 200) begin
				result_bus.ready <= 1'b0;
				repeat (150) @(negedge clk);
				long_hold_done = 1'b1;
			end
			result_bus.ready <= !(gaps_on && $urandom_range(99) < 35);
		end
	end

	always @(posedge clk) begin
		result_t w;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (decoded_q.size() == 0) begin
				$error("unexpected result: kind %0d, out_byte %0h, out_length %0d",
					result_bus.kind, result_bus.out_byte, result_bus.out_length);
				errors++;
			end else begin
				w = decoded_q.pop_front();
				if (result_bus.kind !== w.kind) begin
					$error("kind: expected %0d, got %0d", w.kind, result_bus.kind);
					errors++;
				end
				if (result_bus.out_byte !== w.ob) begin
					$error("out_byte: expected %0h, got %0h", w.ob, result_bus.out_byte);
					errors++;
				end
				if (result_bus.error_code !== w.err) begin
					$error("error_code: expected %0d, got %0d", w.err, result_bus.error_code);
					errors++;
				end
				if (result_bus.out_length !== w.len) begin
					$error("out_length: expected %0d, got %0d", w.len, result_bus.out_length);
					errors++;
				end
				if (result_bus.last !== w.last) begin
					$error("last: expected %0d, got %0d", w.last, result_bus.last);
					errors++;
				end
			end
		end
	end

endmodule

`default_nettype wire
